/* rtl/core/bfa_pkg.sv */
// Shared types and constants for the best-fit block allocator.
// Holds the word structs, opcode and status codes, and the sequencer states.
`default_nettype none

package bfa_pkg;

    localparam int AMT_W = 16;
    localparam int IDX_W = 4;
    localparam int REM_W = 16;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] ST_LOADED    = 3'd0;
    localparam logic [2:0] ST_ALLOCATED = 3'd1;
    localparam logic [2:0] ST_NOFIT     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [AMT_W-1:0] amount;
    } t_in;

    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] block_index;
        logic [REM_W-1:0] remaining;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/best_fit_block_allocator_core.sv */
// Best-fit block allocator: a block table in RAM scanned by one shared comparator.
// Append, clear, unused opcodes and allocate on an empty table go straight to the done state;
// allocate on a loaded table scans, reading one entry per cycle, then writes back and answers.
// One word is in work at a time, so the next word is taken once the answer is registered;
// a held output register keeps the answer waiting and the input stalled.
// Synchronous active-low reset empties the table and the output. Depends on bfa_pkg, bfa_ram.
`default_nettype none

module best_fit_block_allocator_core
    import bfa_pkg::*;
#(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_in,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_out
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [SIZE_BITS-1:0] r_amt, n_amt;
    logic [AW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_issue, n_issue;
    logic             r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]    r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]    r_last, n_last;
    logic             r_found, n_found;
    logic [SIZE_BITS-1:0] r_best_val, n_best_val;
    logic [AW-1:0]    r_best_idx, n_best_idx;
    t_out             r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [SIZE_BITS-1:0] ram_rdata;
    logic [CW-1:0]        last_full;
    logic [SIZE_BITS-1:0] in_amt;
    logic                 fit;

    bfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign last_full = r_count - CW'(1);
    assign in_amt    = SIZE_BITS'(i_in.amount);
    assign fit       = (ram_rdata >= r_amt) && (!r_found || (ram_rdata < r_best_val));
    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_out     = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_amt       = r_amt;
        n_rd_idx    = r_rd_idx;
        n_issue     = r_issue;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_last      = r_last;
        n_found     = r_found;
        n_best_val  = r_best_val;
        n_best_idx  = r_best_idx;
        n_res       = r_res;
        n_out_valid = r_out_valid & i_stall;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_best_idx;
        ram_wdata   = r_best_val - r_amt;
        ram_re      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_amt   = in_amt;
                    n_res   = '{status: ST_NOFIT, block_index: '0, remaining: '0};
                    n_state = S_DONE;
                    unique case (i_in.opcode)
                        OP_APPEND: begin
                            if (r_count == CW'(MAX_BLOCKS)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = in_amt;
                                n_count   = r_count + CW'(1);
                                n_res     = '{status: ST_LOADED,
                                              block_index: IDX_W'(r_count[AW-1:0]),
                                              remaining: REM_W'(in_amt)};
                            end
                        end
                        OP_ALLOC: begin
                            if (r_count != '0) begin
                                n_state   = S_SCAN;
                                n_issue   = 1'b1;
                                n_rd_idx  = '0;
                                n_cmp_vld = 1'b0;
                                n_found   = 1'b0;
                                n_last    = last_full[AW-1:0];
                            end
                        end
                        OP_CLEAR: begin
                            n_count      = '0;
                            n_res.status = ST_CLEARED;
                        end
                        default: begin
                            n_res.status = ST_NOFIT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                ram_re    = r_issue;
                n_cmp_vld = r_issue;
                n_cmp_idx = r_rd_idx;
                if (r_issue) begin
                    if (r_rd_idx == r_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + AW'(1);
                    end
                end
                if (r_cmp_vld) begin
                    if (fit) begin
                        n_found    = 1'b1;
                        n_best_val = ram_rdata;
                        n_best_idx = r_cmp_idx;
                    end
                    if (r_cmp_idx == r_last) begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                n_state = S_DONE;
                if (r_found) begin
                    ram_we = 1'b1;
                    n_res  = '{status: ST_ALLOCATED,
                               block_index: IDX_W'(r_best_idx),
                               remaining: REM_W'(ram_wdata)};
                end else begin
                    n_res = '{status: ST_NOFIT, block_index: '0, remaining: '0};
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue     <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_amt      <= n_amt;
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_last     <= n_last;
        r_found    <= n_found;
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_res      <= n_res;
        r_out      <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BLOCKS))
        else $error("Block count exceeds the table depth.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("A new word was taken before the previous one finished.");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cmp_vld) |-> (r_cmp_idx <= r_last))
        else $error("The scan compared an entry past the last loaded block.");

    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && r_found) |-> (r_best_val >= r_amt))
        else $error("The chosen block is smaller than the request.");
`endif

endmodule

`default_nettype wire

/* rtl/core/bfa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Holds the remaining size of each block; depends on nothing else.
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_best_fit_block_allocator_core.sv */
// Self-checking testbench for best_fit_block_allocator_core: directed and random words with
// bursty input, a patterned output stall and one long output hold-off.
// Depends on bfa_pkg and the allocator RTL; it holds its own predictor in a scoreboard class.
`default_nettype none

module tb_best_fit_block_allocator_core;

    import bfa_pkg::*;

    localparam int         TB_BLOCKS = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    class alloc_scoreboard;
        logic [AMT_W-1:0] blk_size [TB_BLOCKS];
        int unsigned      blk_count;
        t_out             expected_q [$];
        int unsigned      mismatches;
        int unsigned      n_placed;
        int unsigned      n_nofit;
        int unsigned      n_full;

        function new();
            blk_count  = 0;
            mismatches = 0;
            n_placed   = 0;
            n_nofit    = 0;
            n_full     = 0;
        endfunction

        function void note_word(t_in w);
            t_out        e;
            int unsigned best;
            bit          found;
            e = '0;
            case (w.opcode)
                OP_APPEND: begin
                    if (blk_count >= TB_BLOCKS) begin
                        e.status = ST_FULL;
                        n_full++;
                    end else begin
                        blk_size[blk_count] = w.amount;
                        e.status      = ST_LOADED;
                        e.block_index = blk_count[IDX_W-1:0];
                        e.remaining   = w.amount;
                        blk_count++;
                    end
                end
                OP_ALLOC: begin
                    found = 1'b0;
                    best  = 0;
                    for (int unsigned j = 0; j < blk_count; j++) begin
                        if (blk_size[j] >= w.amount && (!found || blk_size[j] < blk_size[best])) begin
                            best  = j;
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        blk_size[best] = blk_size[best] - w.amount;
                        e.status      = ST_ALLOCATED;
                        e.block_index = best[IDX_W-1:0];
                        e.remaining   = blk_size[best];
                        n_placed++;
                    end else begin
                        e.status = ST_NOFIT;
                        n_nofit++;
                    end
                end
                OP_CLEAR: begin
                    blk_count = 0;
                    e.status  = ST_CLEARED;
                end
                default: e.status = ST_NOFIT;
            endcase
            expected_q.push_back(e);
        endfunction

        function void check_word(t_out r);
            t_out e;
            if (expected_q.size() == 0) begin
                $display("%0t: result word with nothing expected: %p", $time, r);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (r.status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, r.status);
                mismatches++;
            end
            if (r.block_index !== e.block_index) begin
                $display("%0t: block_index expected %0d actual %0d", $time,
                         e.block_index, r.block_index);
                mismatches++;
            end
            if (r.remaining !== e.remaining) begin
                $display("%0t: remaining expected %0d actual %0d", $time,
                         e.remaining, r.remaining);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_in;
    logic o_valid;
    logic i_stall;
    t_out o_out;

    alloc_scoreboard sb;
    int              n_sent;
    int              burst_left;
    bit              held_off;

    best_fit_block_allocator_core #(
        .MAX_BLOCKS(TB_BLOCKS),
        .SIZE_BITS (AMT_W)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_in   (i_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out  (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("best_fit_block_allocator_core verification failed");
        $finish;
    end

    function automatic logic [AMT_W-1:0] pick_size();
        case ($urandom_range(0, 3))
            0:       return AMT_W'($urandom_range(0, 15));
            1:       return AMT_W'($urandom_range(0, 1023));
            2:       return AMT_W'($urandom_range(0, 65535));
            default: return AMT_W'($urandom_range(65520, 65535));
        endcase
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [AMT_W-1:0] amt);
        t_in w;
        w.opcode = op;
        w.amount = amt;
        i_valid <= 1'b1;
        i_in    <= w;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_word(w);
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            i_in    <= t_in'($urandom);
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 6);
        end
    endtask

    task automatic run_directed();
        logic [AMT_W-1:0] sizes [16] = '{16'd0, 16'd65535, 16'd100, 16'd100, 16'd50, 16'd1,
                                         16'd32768, 16'd200, 16'd7, 16'd100, 16'd65534,
                                         16'd3, 16'd999, 16'd12345, 16'd50, 16'd2};
        send_word(OP_CLEAR, 16'hA5A5);
        send_word(OP_ALLOC, 16'd0);
        send_word(OP_UNUSED, 16'hFFFF);
        foreach (sizes[k])
            send_word(OP_APPEND, sizes[k]);
        send_word(OP_APPEND, 16'd77);
        send_word(OP_ALLOC, 16'd0);
        send_word(OP_ALLOC, 16'hFFFF);
        send_word(OP_ALLOC, 16'd100);
        send_word(OP_ALLOC, 16'hFFFF);
        send_word(OP_CLEAR, 16'h5A5A);
    endtask

    task automatic run_random(input int target);
        int               n_app;
        int               n_alloc;
        logic [AMT_W-1:0] req;
        while (n_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(2'($urandom_range(0, 3)), AMT_W'($urandom_range(0, 65535)));
            end else begin
                if ($urandom_range(0, 3) != 0)
                    send_word(OP_CLEAR, AMT_W'($urandom_range(0, 65535)));
                n_app = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 18)
                                                     : $urandom_range(0, 8);
                repeat (n_app) send_word(OP_APPEND, pick_size());
                n_alloc = $urandom_range(1, 10);
                repeat (n_alloc) begin
                    case ($urandom_range(0, 7))
                        0:       req = '0;
                        1, 2:    req = (sb.blk_count > 0)
                                     ? sb.blk_size[$urandom_range(0, sb.blk_count - 1)]
                                     : pick_size();
                        default: req = pick_size();
                    endcase
                    send_word(OP_ALLOC, req);
                end
            end
        end
    endtask

    initial begin
        int unsigned rx_cycle;
        int unsigned rx_mode;
        int unsigned hold_cnt;
        rx_cycle = 0;
        rx_mode  = 0;
        hold_cnt = 0;
        held_off = 1'b0;
        i_stall <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && !i_stall)
                sb.check_word(o_out);
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            if (!held_off && n_sent >= 150) begin
                held_off = 1'b1;
                hold_cnt = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else begin
                case (rx_mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= (rx_cycle % 3 != 0);
                endcase
            end
        end
    end

    initial begin
        sb         = new();
        n_sent     = 0;
        burst_left = 4;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_in      <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random(450);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d words: %0d allocations placed, %0d without a fit, %0d appends refused.",
                 n_sent, sb.n_placed, sb.n_nofit, sb.n_full);
        $display("Output held off for a long stretch: %0d, field mismatches: %0d.",
                 held_off, sb.mismatches);
        if (sb.mismatches == 0)
            $display("best_fit_block_allocator_core verification clean");
        else
            $display("best_fit_block_allocator_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
